// ===== design/cws_pkg.sv =====
// shared constants and the pipeline word type of the chebyshev waveshaper
`timescale 1ns / 1ps
package cws_pkg;

    // table size and derived widths
    localparam int MAX_TERMS = 32;
    localparam int SLOT_W    = $clog2(MAX_TERMS);
    localparam int TERMS_W   = $clog2(MAX_TERMS + 1);

    // field widths
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int IDX_W     = 5;
    localparam int CFG_W     = 6;
    localparam int T_W       = SAMPLE_W + 1;
    localparam int PROD_W    = COEF_W + T_W;
    localparam int ACC_W     = PROD_W + SLOT_W + 1;

    // comparison widths
    localparam int CMP_W     = (CFG_W > TERMS_W) ? CFG_W : TERMS_W;
    localparam int SLOT_CMP_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

    // stream packing
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;

    // term count limits and reset value
    localparam int MIN_TERMS    = 2;
    localparam int NUM_TERMS_RST = 32;

    // request kinds
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEFF  = 1'b1;

    // T(0) = 1.0 in Q.15
    localparam logic signed [T_W-1:0] T_ONE = T_W'(32768);

    // word that moves down the term pipeline
    typedef struct packed {
        logic                       valid;
        logic                       wr;
        logic signed [SAMPLE_W-1:0] x;
        logic signed [T_W-1:0]      t1;
        logic signed [T_W-1:0]      t2;
        logic signed [ACC_W-1:0]    acc;
        logic [IDX_W-1:0]           idx;
        logic signed [COEF_W-1:0]   val;
    } t_item;

endpackage

// ===== design/cws_term_stage.sv =====
// one pipeline stage per polynomial term, holding that term's weight
`timescale 1ns / 1ps
module cws_term_stage (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  logic [cws_pkg::SLOT_W-1:0]     i_slot,
    input  logic                           i_active,
    input  cws_pkg::t_item                 i_item,
    output cws_pkg::t_item                 o_item
);
    import cws_pkg::*;

    localparam int RND_W = PROD_W - 14;
    localparam int TN_W  = RND_W + 1;

    logic signed [COEF_W-1:0] r_weight;
    t_item                    r_item;
    t_item                    n_item;

    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_prod_rnd;
    logic signed [RND_W-1:0]  w_half;
    logic signed [TN_W-1:0]   w_tn_raw;
    logic signed [T_W-1:0]    w_tn;
    logic signed [PROD_W-1:0] w_wprod;
    logic                     w_hit;

    // recurrence: 2x*T(m-1) rounded half up, minus T(m-2), kept to [-1, 1]
    assign w_prod     = PROD_W'(i_item.x) * PROD_W'(i_item.t1);
    assign w_prod_rnd = w_prod + PROD_W'(8192);
    assign w_half     = w_prod_rnd[PROD_W-1:14];
    assign w_tn_raw   = TN_W'(w_half) - TN_W'(i_item.t2);

    always_comb begin
        if (w_tn_raw > TN_W'(32768)) begin
            w_tn = T_W'(32768);
        end else if (w_tn_raw < -TN_W'(32768)) begin
            w_tn = -T_W'(32768);
        end else begin
            w_tn = w_tn_raw[T_W-1:0];
        end
    end

    // weighted term into the running sum
    assign w_wprod = PROD_W'(r_weight) * PROD_W'(i_item.t1);

    always_comb begin
        n_item     = i_item;
        n_item.t2  = i_item.t1;
        n_item.t1  = w_tn;
        n_item.acc = i_active ? (i_item.acc + ACC_W'(w_wprod)) : i_item.acc;
    end

    // a coefficient word updates this slot as it passes
    assign w_hit = i_item.valid && (i_item.wr == REQ_COEFF) &&
                   (SLOT_CMP_W'(i_item.idx) == SLOT_CMP_W'(i_slot));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= '0;
        end else if (i_adv && w_hit) begin
            r_weight <= i_item.val;
        end
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item <= '0;
        end else if (i_adv) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

// ===== design/chebyshev_waveshaper_unit.sv =====
// top level of the chebyshev polynomial waveshaper
`timescale 1ns / 1ps
// Shapes Q1.15 samples with a weighted sum of Chebyshev polynomials T(1)..T(n),
// weights Q4.12 held one per pipeline stage, result rounded and saturated to
// Q1.15 with a clip flag in tuser. A word on the input is either a sample
// (tuser 0) or a coefficient write (tuser 1, no output word). The datapath is
// one register stage per polynomial term, plus an input and an output
// register: a word may enter every cycle unless the output stalls, and its
// result passes the input register, each term stage and the output register.
// Coefficient writes travel down the same pipeline, so a sample always sees
// the weights written before it. A stall on the output holds the whole pipeline.
// The user writes num_terms only while the block is empty; the block itself does not enforce it.
module chebyshev_waveshaper_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_wr_en,
    input  logic [cws_pkg::CFG_W-1:0]         i_cfg_wr_data,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [15:0] sample_in, [20:16] coeff_index, [36:21] coeff_value, rest zero
    input  logic [cws_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // [0] req_type
    input  logic                              s_axis_tuser,
    // output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [15:0] sample_out
    output logic [cws_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // [0] clipped
    output logic                              m_axis_tuser
);
    import cws_pkg::*;

    localparam int Y_W = ACC_W - 12;

    logic [CFG_W-1:0]         r_num_terms;
    t_item                    r_in;
    t_item                    n_in;
    t_item                    w_pos [MAX_TERMS+1];
    logic [MAX_TERMS-1:0]     w_active;
    logic [CMP_W-1:0]         w_n_cmp;
    logic                     w_adv;

    logic                     r_out_valid;
    logic [M_TDATA_W-1:0]     r_out_data;
    logic                     r_out_clip;

    logic signed [ACC_W-1:0]  w_acc_rnd;
    logic signed [Y_W-1:0]    w_y;
    logic                     w_hi;
    logic                     w_lo;
    logic [SAMPLE_W-1:0]      w_sat;

    // whole pipeline moves when the output slot is free or being taken
    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_adv;

    // term count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_terms <= CFG_W'(NUM_TERMS_RST);
        end else if (i_cfg_wr_en) begin
            r_num_terms <= i_cfg_wr_data;
        end
    end

    // effective term count and per-stage enables
    always_comb begin
        if (CMP_W'(r_num_terms) < CMP_W'(MIN_TERMS)) begin
            w_n_cmp = CMP_W'(MIN_TERMS);
        end else if (CMP_W'(r_num_terms) > CMP_W'(MAX_TERMS)) begin
            w_n_cmp = CMP_W'(MAX_TERMS);
        end else begin
            w_n_cmp = CMP_W'(r_num_terms);
        end
        for (int j = 0; j < MAX_TERMS; j++) begin
            w_active[j] = (CMP_W'(j) < w_n_cmp);
        end
    end

    // input register: seed the recurrence with T(1) = x, T(0) = 1
    always_comb begin
        n_in.valid = s_axis_tvalid;
        n_in.wr    = s_axis_tuser;
        n_in.x     = $signed(s_axis_tdata[SAMPLE_W-1:0]);
        n_in.t1    = T_W'($signed(s_axis_tdata[SAMPLE_W-1:0]));
        n_in.t2    = T_ONE;
        n_in.acc   = '0;
        n_in.idx   = s_axis_tdata[SAMPLE_W+IDX_W-1:SAMPLE_W];
        n_in.val   = $signed(s_axis_tdata[SAMPLE_W+IDX_W+COEF_W-1:SAMPLE_W+IDX_W]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in <= '0;
        end else if (w_adv) begin
            r_in <= n_in;
        end
    end

    assign w_pos[0] = r_in;

    // one stage per term
    for (genvar j = 0; j < MAX_TERMS; j++) begin : g_term
        cws_term_stage u_stage (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (w_adv),
            .i_slot   (SLOT_W'(j)),
            .i_active (w_active[j]),
            .i_item   (w_pos[j]),
            .o_item   (w_pos[j+1])
        );
    end

    // round to Q.15 and saturate
    assign w_acc_rnd = w_pos[MAX_TERMS].acc + ACC_W'(2048);
    assign w_y       = w_acc_rnd[ACC_W-1:12];
    assign w_hi      = (w_y > Y_W'(32767));
    assign w_lo      = (w_y < -Y_W'(32768));

    always_comb begin
        if (w_hi) begin
            w_sat = SAMPLE_W'(16'h7FFF);
        end else if (w_lo) begin
            w_sat = SAMPLE_W'(16'h8000);
        end else begin
            w_sat = w_y[SAMPLE_W-1:0];
        end
    end

    // output register: only samples give a word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_pos[MAX_TERMS].valid && (w_pos[MAX_TERMS].wr == REQ_SAMPLE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= M_TDATA_W'(w_sat);
            r_out_clip <= w_hi || w_lo;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_clip;

endmodule

// ===== bench/tb_chebyshev_waveshaper_unit.sv =====
// testbench for the chebyshev waveshaper: directed table, random words, self-checking predictor
`timescale 1ns / 1ps
module tb_chebyshev_waveshaper_unit;
    import cws_pkg::*;

    // timing and run length
    localparam int LATENCY         = MAX_TERMS + 2;
    localparam int DRAIN_CYCLES    = LATENCY + 16;
    localparam int HOLD_CYCLES     = 250;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int NUM_PHASES      = 8;
    localparam int WORDS_PER_PHASE = 48;
    localparam int NUM_ROWS        = 23;

    // one shaped result as it leaves the block
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_out;
        logic                clipped;
    } t_shaped;

    // one row of the directed table; exp_* only meaningful when typed is set
    typedef struct {
        logic                kind;
        logic [SAMPLE_W-1:0] smp;
        logic [IDX_W-1:0]    slot;
        logic [COEF_W-1:0]   wgt;
        bit                  typed;
        logic [SAMPLE_W-1:0] exp_out;
        logic                exp_clip;
    } t_stim_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_W-1:0]     i_cfg_wr_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;

    // predictor state: weights and term count as the block should hold them
    logic signed [COEF_W-1:0] weight_copy [MAX_TERMS];
    logic [CFG_W-1:0]         terms_copy;
    t_shaped                  expected_shaped [$];

    int mismatches   = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit hold_req     = 1'b0;
    int hold_left    = 0;
    int cycle_count  = 0;

    t_stim_row directed_rows [NUM_ROWS] = '{
        // table cleared at reset: every sample shapes to zero
        '{REQ_SAMPLE, 16'h7FFF, 5'd0,  16'h0000, 1'b1, 16'h0000, 1'b0},
        '{REQ_SAMPLE, 16'h8000, 5'd0,  16'h0000, 1'b1, 16'h0000, 1'b0},
        '{REQ_SAMPLE, 16'h0000, 5'd0,  16'h0000, 1'b1, 16'h0000, 1'b0},
        // largest first-order weight saturates at both ends of the input
        '{REQ_COEFF,  16'h0000, 5'd0,  16'h7FFF, 1'b0, 16'h0000, 1'b0},
        '{REQ_SAMPLE, 16'h7FFF, 5'd0,  16'h0000, 1'b1, 16'h7FFF, 1'b1},
        '{REQ_SAMPLE, 16'h8000, 5'd0,  16'h0000, 1'b1, 16'h8000, 1'b1},
        '{REQ_SAMPLE, 16'h0000, 5'd0,  16'h0000, 1'b1, 16'h0000, 1'b0},
        // most negative weight flips the saturation
        '{REQ_COEFF,  16'h0000, 5'd0,  16'h8000, 1'b0, 16'h0000, 1'b0},
        '{REQ_SAMPLE, 16'h7FFF, 5'd0,  16'h0000, 1'b1, 16'h8000, 1'b1},
        '{REQ_SAMPLE, 16'h8000, 5'd0,  16'h0000, 1'b1, 16'h7FFF, 1'b1},
        // mixed weights including the last slot
        '{REQ_COEFF,  16'h0000, 5'd0,  16'h1000, 1'b0, 16'h0000, 1'b0},
        '{REQ_COEFF,  16'h0000, 5'd31, 16'h1000, 1'b0, 16'h0000, 1'b0},
        '{REQ_COEFF,  16'h0000, 5'd2,  16'hF800, 1'b0, 16'h0000, 1'b0},
        '{REQ_SAMPLE, 16'h4000, 5'd0,  16'h0000, 1'b0, 16'h0000, 1'b0},
        '{REQ_SAMPLE, 16'hC000, 5'd0,  16'h0000, 1'b0, 16'h0000, 1'b0},
        '{REQ_SAMPLE, 16'h7FFF, 5'd0,  16'h0000, 1'b0, 16'h0000, 1'b0},
        '{REQ_SAMPLE, 16'h8000, 5'd0,  16'h0000, 1'b0, 16'h0000, 1'b0},
        '{REQ_COEFF,  16'h0000, 5'd31, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
        '{REQ_SAMPLE, 16'h8000, 5'd0,  16'h0000, 1'b0, 16'h0000, 1'b0},
        '{REQ_SAMPLE, 16'd12345, 5'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{REQ_COEFF,  16'h0000, 5'd0,  16'h0000, 1'b0, 16'h0000, 1'b0},
        '{REQ_SAMPLE, 16'h0001, 5'd0,  16'h0000, 1'b0, 16'h0000, 1'b0},
        '{REQ_SAMPLE, 16'hFFFF, 5'd0,  16'h0000, 1'b0, 16'h0000, 1'b0}
    };

    // term counts per random phase, out-of-range values among them
    logic [CFG_W-1:0] term_plan [NUM_PHASES] = '{
        6'd2, 6'd0, 6'd1, 6'd63, 6'd33, 6'd17, 6'd5, 6'd32
    };

    // sample extremes mixed into the random words
    logic [SAMPLE_W-1:0] extremes [5] = '{16'h7FFF, 16'h8000, 16'h0000,
                                          16'h0001, 16'hFFFF};

    chebyshev_waveshaper_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // weighted chebyshev sum with the block's rounding and saturation
    function automatic t_shaped shape_sample(input logic signed [SAMPLE_W-1:0] x);
        longint  xs;
        longint  t_prev;
        longint  t_prev2;
        longint  t_next;
        longint  acc;
        longint  y;
        int      n;
        int      k;
        t_shaped r;
        n = int'(terms_copy);
        if (n < MIN_TERMS) n = MIN_TERMS;
        if (n > MAX_TERMS) n = MAX_TERMS;
        xs      = x;
        t_prev2 = 32768;
        t_prev  = xs;
        acc     = longint'(weight_copy[0]) * t_prev;
        for (k = 1; k < n; k++) begin
            // 2x*T(m-1) rounded half up, minus T(m-2), held to the range of T
            t_next = ((xs * t_prev + 8192) >>> 14) - t_prev2;
            if (t_next > 32768) t_next = 32768;
            if (t_next < -32768) t_next = -32768;
            acc     += longint'(weight_copy[k]) * t_next;
            t_prev2 = t_prev;
            t_prev  = t_next;
        end
        y = (acc + 2048) >>> 12;
        r.clipped = (y > 32767) || (y < -32768);
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        r.sample_out = y[SAMPLE_W-1:0];
        return r;
    endfunction

    // offer one word, wait for acceptance, then update the predictor
    task automatic send_word(input logic kind, input logic [SAMPLE_W-1:0] smp,
                             input logic [IDX_W-1:0] slot, input logic [COEF_W-1:0] wgt,
                             input bit typed, input t_shaped typed_res);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {3'b000, wgt, slot, smp};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (kind == REQ_COEFF) begin
            weight_copy[slot] = wgt;
        end else if (typed) begin
            expected_shaped.push_back(typed_res);
        end else begin
            expected_shaped.push_back(shape_sample(smp));
        end
    endtask

    // let every result arrive and the pipeline empty of coefficient writes
    task automatic drain_block();
        while (expected_shaped.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_num_terms(input logic [CFG_W-1:0] val);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= val;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        terms_copy    = val;
    endtask

    // stimulus
    initial begin
        int                  row;
        int                  p;
        int                  i;
        logic                kind;
        logic [SAMPLE_W-1:0] smp;
        logic [IDX_W-1:0]    slot;
        logic [COEF_W-1:0]   wgt;
        t_shaped             typed_res;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= REQ_SAMPLE;
        for (i = 0; i < MAX_TERMS; i++) weight_copy[i] = '0;
        terms_copy = CFG_W'(NUM_TERMS_RST);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table at the reset term count
        for (row = 0; row < NUM_ROWS; row++) begin
            typed_res.sample_out = directed_rows[row].exp_out;
            typed_res.clipped    = directed_rows[row].exp_clip;
            send_word(directed_rows[row].kind, directed_rows[row].smp,
                      directed_rows[row].slot, directed_rows[row].wgt,
                      directed_rows[row].typed, typed_res);
        end
        s_axis_tvalid <= 1'b0;

        // random phases, each with its own term count and idling pattern
        for (p = 0; p < NUM_PHASES; p++) begin
            drain_block();
            write_num_terms(term_plan[p]);
            case (p % 4)
                0: begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct = 70;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 70;
                end
                default: begin
                    tx_idle_pct = 28;
                    rx_stall_pct = 28;
                end
            endcase
            // long output hold-off while the sender keeps offering words
            if (p == 0) hold_req = 1'b1;
            for (i = 0; i < WORDS_PER_PHASE; i++) begin
                kind = ($urandom_range(0, 99) < 30) ? REQ_COEFF : REQ_SAMPLE;
                if ($urandom_range(0, 9) == 0)
                    smp = extremes[$urandom_range(0, 4)];
                else
                    smp = SAMPLE_W'($urandom);
                slot = IDX_W'($urandom);
                if ($urandom_range(0, 2) == 0)
                    wgt = COEF_W'($urandom);
                else
                    wgt = COEF_W'(int'($urandom_range(0, 4095)) - 2048);
                typed_res = '0;
                send_word(kind, smp, slot, wgt, 1'b0, typed_res);
            end
            s_axis_tvalid <= 1'b0;
        end

        drain_block();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // output side: random stalls, one long hold-off, and the result check
    always @(posedge i_clk) begin
        t_shaped want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (expected_shaped.size() == 0) begin
                $display("%0t: unexpected word sample_out=%h clipped=%b", $time,
                         m_axis_tdata, m_axis_tuser);
                mismatches++;
            end else begin
                want = expected_shaped.pop_front();
                if (m_axis_tdata !== want.sample_out) begin
                    $display("%0t: sample_out expected %h actual %h", $time,
                             want.sample_out, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tuser !== want.clipped) begin
                    $display("%0t: clipped expected %b actual %b", $time,
                             want.clipped, m_axis_tuser);
                    mismatches++;
                end
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/cws_pkg.sv
design/cws_term_stage.sv
design/chebyshev_waveshaper_unit.sv
bench/tb_chebyshev_waveshaper_unit.sv
